[rtl/core/c2d_pkg.sv]
// ----------------------------------------------------------------------------
// c2d_pkg
// shared types and constants for the conv2d mac unit
// ----------------------------------------------------------------------------
package c2d_pkg;

  localparam int DEF_MAX_HEIGHT = 16;
  localparam int DEF_MAX_WIDTH  = 16;
  localparam int DEF_MAX_IN_CH  = 16;
  localparam int DEF_MAX_OUT_CH = 16;
  localparam int DEF_MAX_KERNEL = 5;

  localparam int ACC_W = 40;

  typedef enum logic [1:0] {
    KIND_LOAD_ACT  = 2'd0,
    KIND_LOAD_WGT  = 2'd1,
    KIND_LOAD_BIAS = 2'd2,
    KIND_COMPUTE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_KH  = 3'd0,
    REG_KW  = 3'd1,
    REG_PAD = 3'd2,
    REG_IH  = 3'd3,
    REG_IW  = 3'd4,
    REG_IC  = 3'd5,
    REG_OC  = 3'd6
  } reg_idx_t;

  // queued request from front to back
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [3:0]  in_ch;
    logic [3:0]  out_ch;
    logic [2:0]  tap_row;
    logic [2:0]  tap_col;
    logic [15:0] value;
  } req_t;

  // clamped geometry seen by the back end
  typedef struct packed {
    logic [6:0] kh;
    logic [6:0] kw;
    logic [2:0] pad;
    logic [6:0] ih;
    logic [6:0] iw;
    logic [6:0] nic;
    logic [6:0] noc;
  } geom_t;

  // round half up from q24.16 to q8.8, then saturate
  function automatic logic [15:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0] r;
    logic signed [ACC_W-8:0] q;
    begin
      r = {acc[ACC_W-1], acc} + (ACC_W+1)'(128);
      q = r[ACC_W:8];
      if (q > (ACC_W-7)'(32767)) round_sat = 16'h7fff;
      else if (q < -(ACC_W-7)'(32768)) round_sat = 16'h8000;
      else round_sat = q[15:0];
    end
  endfunction

endpackage

[rtl/core/c2d_front.sv]
// ----------------------------------------------------------------------------
// c2d_front
// accepts requests, holds config registers, feeds a short request queue
// ----------------------------------------------------------------------------
module c2d_front #(
  parameter int MAX_HEIGHT = c2d_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH  = c2d_pkg::DEF_MAX_WIDTH,
  parameter int MAX_IN_CH  = c2d_pkg::DEF_MAX_IN_CH,
  parameter int MAX_OUT_CH = c2d_pkg::DEF_MAX_OUT_CH,
  parameter int MAX_KERNEL = c2d_pkg::DEF_MAX_KERNEL
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  logic [1:0]     kind,
  input  logic [3:0]     row,
  input  logic [3:0]     col,
  input  logic [3:0]     in_ch,
  input  logic [3:0]     out_ch,
  input  logic [2:0]     tap_row,
  input  logic [2:0]     tap_col,
  input  logic [15:0]    value,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [4:0]     cfg_data,
  output c2d_pkg::req_t  q_req,
  output logic           q_valid,
  input  logic           q_pop,
  output c2d_pkg::geom_t geom
);
  import c2d_pkg::*;

  logic [2:0] kh_r, kw_r, pad_r;
  logic [4:0] ih_r, iw_r, ic_r, oc_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      kh_r <= 3'd3; kw_r <= 3'd3; pad_r <= 3'd1;
      ih_r <= 5'd16; iw_r <= 5'd16; ic_r <= 5'd16; oc_r <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KH:  kh_r  <= cfg_data[2:0];
        REG_KW:  kw_r  <= cfg_data[2:0];
        REG_PAD: pad_r <= cfg_data[2:0];
        REG_IH:  ih_r  <= cfg_data;
        REG_IW:  iw_r  <= cfg_data;
        REG_IC:  ic_r  <= cfg_data;
        REG_OC:  oc_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [6:0] clamp(input logic [4:0] v, input int lo, input int hi);
    begin
      if (int'(v) < lo) clamp = 7'(lo);
      else if (int'(v) > hi) clamp = 7'(hi);
      else clamp = 7'(v);
    end
  endfunction

  always_comb begin
    geom.kh  = clamp({2'b0, kh_r}, 0, MAX_KERNEL);
    geom.kw  = clamp({2'b0, kw_r}, 0, MAX_KERNEL);
    geom.pad = pad_r;
    geom.ih  = clamp(ih_r, 0, MAX_HEIGHT);
    geom.iw  = clamp(iw_r, 0, MAX_WIDTH);
    geom.nic = clamp(ic_r, 0, MAX_IN_CH);
    geom.noc = clamp(oc_r, 1, MAX_OUT_CH);
  end

  // two-entry request queue
  req_t       slot [2];
  logic [1:0] count;
  logic       rd_ptr, wr_ptr;
  logic       push;

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_req   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{kind: kind, row: row, col: col, in_ch: in_ch, out_ch: out_ch,
                        tap_row: tap_row, tap_col: tap_col, value: value};
    end
    if (rst) begin
      count <= 2'd0; rd_ptr <= 1'b0; wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

[rtl/core/c2d_back.sv]
// ----------------------------------------------------------------------------
// c2d_back
// executes loads and walks the kernel window for compute requests
// ----------------------------------------------------------------------------
module c2d_back #(
  parameter int MAX_HEIGHT = c2d_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH  = c2d_pkg::DEF_MAX_WIDTH,
  parameter int MAX_IN_CH  = c2d_pkg::DEF_MAX_IN_CH,
  parameter int MAX_OUT_CH = c2d_pkg::DEF_MAX_OUT_CH,
  parameter int MAX_KERNEL = c2d_pkg::DEF_MAX_KERNEL
) (
  input  logic           clk,
  input  logic           rst,
  input  c2d_pkg::req_t  q_req,
  input  logic           q_valid,
  output logic           q_pop,
  input  c2d_pkg::geom_t geom,
  output logic           done,
  output logic [3:0]     channel,
  output logic [15:0]    result,
  output logic           last
);
  import c2d_pkg::*;

  localparam int ACT_DEPTH = MAX_HEIGHT * MAX_WIDTH * MAX_IN_CH;
  localparam int WGT_ROWS  = MAX_KERNEL * MAX_KERNEL * MAX_IN_CH;
  localparam int AW  = $clog2(ACT_DEPTH > 1 ? ACT_DEPTH : 2);
  localparam int WRW = $clog2(WGT_ROWS > 1 ? WGT_ROWS : 2);
  localparam int OW  = $clog2(MAX_OUT_CH > 1 ? MAX_OUT_CH : 2);

  // activations; weights stored one row per (tap, in_ch) across all out channels
  logic [15:0] act_mem [ACT_DEPTH];
  logic [15:0] wgt_mem [MAX_OUT_CH][WGT_ROWS];
  logic [15:0] bias_reg [MAX_OUT_CH];
  logic signed [ACC_W-1:0] acc [MAX_OUT_CH];

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ADDR  = 6'b000010,
    S_READ  = 6'b000100,
    S_MUL   = 6'b001000,
    S_ACC   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;
  state_t state;

  req_t cur;
  logic [2:0] ky, kx;
  logic [6:0] c;
  logic [6:0] o;
  logic       tap_ok, last_step;
  logic signed [7:0] y, x;
  logic [AW-1:0]  act_addr;
  logic [WRW-1:0] wrow;
  logic [15:0] act_q;
  logic [15:0] wgt_q [MAX_OUT_CH];
  logic signed [31:0] prod [MAX_OUT_CH];
  logic        prod_ok;

  assign y = 8'(cur.row) + 8'(ky) - 8'(geom.pad);
  assign x = 8'(cur.col) + 8'(kx) - 8'(geom.pad);
  assign tap_ok = (y >= 0) && (y < $signed({1'b0, geom.ih})) &&
                  (x >= 0) && (x < $signed({1'b0, geom.iw})) &&
                  (7'(ky) < geom.kh) && (7'(kx) < geom.kw) && (c < geom.nic);
  assign act_addr = AW'((32'(y) * MAX_WIDTH + 32'(x)) * MAX_IN_CH + 32'(c));
  assign wrow = WRW'((32'(ky) * MAX_KERNEL + 32'(kx)) * MAX_IN_CH + 32'(c));

  // last window step when the channel, column and row counters all wrap
  assign last_step = (c + 7'd1 >= geom.nic) && (7'(kx) + 7'd1 >= geom.kw) &&
                     (7'(ky) + 7'd1 >= geom.kh);

  assign q_pop = (state == S_IDLE) && q_valid;

  // load path
  always_ff @(posedge clk) begin
    if (q_pop) begin
      case (q_req.kind)
        KIND_LOAD_ACT:
          if (int'(q_req.row) < MAX_HEIGHT && int'(q_req.col) < MAX_WIDTH &&
              int'(q_req.in_ch) < MAX_IN_CH)
            act_mem[AW'((32'(q_req.row) * MAX_WIDTH + 32'(q_req.col)) * MAX_IN_CH
                        + 32'(q_req.in_ch))] <= q_req.value;
        KIND_LOAD_WGT:
          if (int'(q_req.tap_row) < MAX_KERNEL && int'(q_req.tap_col) < MAX_KERNEL &&
              int'(q_req.in_ch) < MAX_IN_CH && int'(q_req.out_ch) < MAX_OUT_CH)
            wgt_mem[OW'(q_req.out_ch)][WRW'((32'(q_req.tap_row) * MAX_KERNEL
                + 32'(q_req.tap_col)) * MAX_IN_CH + 32'(q_req.in_ch))] <= q_req.value;
        KIND_LOAD_BIAS:
          if (int'(q_req.out_ch) < MAX_OUT_CH) bias_reg[OW'(q_req.out_ch)] <= q_req.value;
        default: ;
      endcase
    end
  end

  // registered memory reads
  always_ff @(posedge clk) begin
    act_q <= act_mem[act_addr];
    for (int i = 0; i < MAX_OUT_CH; i++) wgt_q[i] <= wgt_mem[i][wrow];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_OUT_CH; i++)
      prod[i] <= $signed(act_q) * $signed(wgt_q[i]);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < MAX_OUT_CH; i++) acc[i] <= '0;
    end else begin
      case (state)
        S_IDLE:
          if (q_valid && q_req.kind == KIND_COMPUTE) begin
            cur <= q_req;
            ky <= '0; kx <= '0; c <= '0; o <= '0;
            for (int i = 0; i < MAX_OUT_CH; i++)
              acc[i] <= ACC_W'($signed(bias_reg[i])) <<< 8;
            state <= S_ADDR;
          end
        S_ADDR: state <= S_READ;
        S_READ: begin
          prod_ok <= tap_ok;
          state <= S_MUL;
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          if (prod_ok)
            for (int i = 0; i < MAX_OUT_CH; i++) acc[i] <= acc[i] + ACC_W'(prod[i]);
          if (last_step) begin
            state <= S_EMIT;
          end else begin
            if (c + 7'd1 < geom.nic) c <= c + 7'd1;
            else begin
              c <= '0;
              if (7'(kx) + 7'd1 < geom.kw) kx <= kx + 3'd1;
              else begin
                kx <= '0;
                ky <= ky + 3'd1;
              end
            end
            state <= S_ADDR;
          end
        end
        S_EMIT: begin
          done    <= 1'b1;
          channel <= 4'(o);
          result  <= round_sat(acc[OW'(o)]);
          last    <= (o + 7'd1 == geom.noc);
          if (o + 7'd1 == geom.noc) state <= S_IDLE;
          o <= o + 7'd1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/conv2d_forward_mac_unit.sv]
// ----------------------------------------------------------------------------
// conv2d_forward_mac_unit
// zero-padded nhwc 2d convolution, one output pixel per compute request
// ----------------------------------------------------------------------------
//  channel   ports                                         handshake
//  request   kind row col in_ch out_ch tap_row tap_col value  start & !busy
//  result    channel result last                           done, one cycle
//  config    cfg_we cfg_index cfg_data                     cfg_we
//
//  a load is written to its store as the back end pops it; a compute
//  request walks kh * kw * in_channels steps (address, memory read,
//  multiply, accumulate), all output channels in parallel lanes, then emits
//  one result per output channel on consecutive cycles
//  the window walk of the back end sets the rate, one step per tap even
//  when the tap is skipped
//  a two-entry request queue lets requests arrive while a pixel computes
//  rst is synchronous; stores keep no reset, results cannot be stalled
// ----------------------------------------------------------------------------
module conv2d_forward_mac_unit #(
  parameter int MAX_HEIGHT = c2d_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH  = c2d_pkg::DEF_MAX_WIDTH,
  parameter int MAX_IN_CH  = c2d_pkg::DEF_MAX_IN_CH,
  parameter int MAX_OUT_CH = c2d_pkg::DEF_MAX_OUT_CH,
  parameter int MAX_KERNEL = c2d_pkg::DEF_MAX_KERNEL
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [3:0]  row,
  input  logic [3:0]  col,
  input  logic [3:0]  in_ch,
  input  logic [3:0]  out_ch,
  input  logic [2:0]  tap_row,
  input  logic [2:0]  tap_col,
  input  logic [15:0] value,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  output logic        done,
  output logic [3:0]  channel,
  output logic [15:0] result,
  output logic        last
);
  import c2d_pkg::*;

  req_t  q_req;
  logic  q_valid, q_pop;
  geom_t geom;

  // front end: config registers and request queue
  c2d_front #(
    .MAX_HEIGHT(MAX_HEIGHT), .MAX_WIDTH(MAX_WIDTH), .MAX_IN_CH(MAX_IN_CH),
    .MAX_OUT_CH(MAX_OUT_CH), .MAX_KERNEL(MAX_KERNEL)
  ) u_front (
    .clk, .rst, .start, .busy, .kind, .row, .col, .in_ch, .out_ch,
    .tap_row, .tap_col, .value, .cfg_we, .cfg_index, .cfg_data,
    .q_req, .q_valid, .q_pop, .geom
  );

  // back end: stores, window walk and output lanes
  c2d_back #(
    .MAX_HEIGHT(MAX_HEIGHT), .MAX_WIDTH(MAX_WIDTH), .MAX_IN_CH(MAX_IN_CH),
    .MAX_OUT_CH(MAX_OUT_CH), .MAX_KERNEL(MAX_KERNEL)
  ) u_back (
    .clk, .rst, .q_req, .q_valid, .q_pop, .geom,
    .done, .channel, .result, .last
  );

endmodule
